[rtl/core/lsp_pkg.sv]
// lsp_pkg: shared types, codes and widths of the lifo stack with peek
// used by lsp_cell, lsp_ctrl and lifo_stack_with_peek; no dependencies
package lsp_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 7;
    localparam int CAP_W     = 7;
    localparam int STAT_W    = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
    localparam logic [WORD_W-1:0] ERR_WORD  = '1;

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS    = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE,
        S_PEEK
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
        logic probe_load;
        logic probe_shift;
    } t_cell_ctl;

endpackage

[rtl/core/lsp_cell.sv]
// lsp_cell: one stack entry plus one probe register of the peek scan chain
// depends on lsp_pkg
module lsp_cell (
    input  logic                        i_clk,
    input  lsp_pkg::t_cell_ctl          i_ctl,
    input  logic [lsp_pkg::WORD_W-1:0]  i_up_data,
    input  logic [lsp_pkg::WORD_W-1:0]  i_dn_data,
    input  logic [lsp_pkg::WORD_W-1:0]  i_dn_probe,
    output logic [lsp_pkg::WORD_W-1:0]  o_data,
    output logic [lsp_pkg::WORD_W-1:0]  o_probe
);
    import lsp_pkg::*;

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic [WORD_W-1:0] r_probe;
    logic [WORD_W-1:0] n_probe;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push) begin
            n_data = i_up_data;
        end else if (i_ctl.pop) begin
            n_data = i_dn_data;
        end
    end

    always_comb begin
        n_probe = r_probe;
        if (i_ctl.probe_load) begin
            n_probe = r_data;
        end else if (i_ctl.probe_shift) begin
            n_probe = i_dn_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_probe <= n_probe;
    end

    assign o_data  = r_data;
    assign o_probe = r_probe;

endmodule

[rtl/core/lsp_ctrl.sv]
// lsp_ctrl: request decode, entry count, capacity register, peek scan and result register
// depends on lsp_pkg; drives the lsp_cell chain
module lsp_ctrl #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lsp_pkg::KIND_W-1:0]  i_kind,
    input  logic [lsp_pkg::POS_W-1:0]   i_position,
    input  logic                        i_cfg_we,
    input  logic [lsp_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic [lsp_pkg::WORD_W-1:0]  i_top_data,
    input  logic [lsp_pkg::WORD_W-1:0]  i_top_probe,
    output lsp_pkg::t_cell_ctl          o_cell_ctl,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lsp_pkg::WORD_W-1:0]  o_read_value,
    output logic [lsp_pkg::STAT_W-1:0]  o_status,
    output logic                        o_is_empty,
    output logic                        o_is_full
);
    import lsp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = (CW > POS_W) ? CW : POS_W;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_peek_cnt;
    logic [CW-1:0]     n_peek_cnt;
    logic [CAP_W-1:0]  r_capacity;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_read_value;
    logic [STAT_W-1:0] r_status;
    logic              r_is_empty;
    logic              r_is_full;

    logic              accept;
    logic              out_load;
    logic              peek_ok;
    logic              full;
    logic [W-1:0]      count_w;
    logic [W-1:0]      next_count_w;
    logic [W-1:0]      pos_w;
    logic [W-1:0]      pos_m1;
    logic [W-1:0]      cap_w;
    logic [W-1:0]      cap_eff;
    logic [WORD_W-1:0] res_value;
    logic [STAT_W-1:0] res_status;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign count_w = W'(r_count);
    assign pos_w   = W'(i_position);
    assign pos_m1  = pos_w - W'(1);
    assign cap_w   = W'(r_capacity);

    always_comb begin
        if (cap_w == '0) begin
            cap_eff = W'(1);
        end else if (cap_w > W'(DEPTH)) begin
            cap_eff = W'(DEPTH);
        end else begin
            cap_eff = cap_w;
        end
    end

    assign full    = count_w >= cap_eff;
    assign peek_ok = (pos_w != '0) && (pos_w <= count_w);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_PEEK) && peek_ok) begin
                    n_state = S_PEEK;
                end
            end
            S_PEEK: begin
                if (r_peek_cnt == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_cell_ctl = '0;
        n_count    = r_count;
        n_peek_cnt = r_peek_cnt;
        out_load   = 1'b0;
        res_value  = ERR_WORD;
        res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PUSH: begin
                            out_load = 1'b1;
                            if (full) begin
                                res_status = ST_OVERFLOW;
                            end else begin
                                o_cell_ctl.push = 1'b1;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        KIND_POP: begin
                            out_load = 1'b1;
                            if (r_count == '0) begin
                                res_status = ST_UNDERFLOW;
                            end else begin
                                o_cell_ctl.pop = 1'b1;
                                n_count        = r_count - 1'b1;
                                res_value      = i_top_data;
                            end
                        end
                        KIND_PEEK: begin
                            if (peek_ok) begin
                                o_cell_ctl.probe_load = 1'b1;
                                n_peek_cnt            = pos_m1[CW-1:0];
                            end else begin
                                out_load   = 1'b1;
                                res_status = ST_BADPOS;
                            end
                        end
                        default: begin
                            out_load   = 1'b1;
                            res_status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_PEEK: begin
                if (r_peek_cnt == '0) begin
                    out_load  = 1'b1;
                    res_value = i_top_probe;
                end else begin
                    o_cell_ctl.probe_shift = 1'b1;
                    n_peek_cnt             = r_peek_cnt - 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign next_count_w = W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_peek_cnt <= n_peek_cnt;
        if (out_load) begin
            r_read_value <= res_value;
            r_status     <= res_status;
            r_is_empty   <= (n_count == '0);
            r_is_full    <= (next_count_w >= cap_eff);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_is_empty   = r_is_empty;
    assign o_is_full    = r_is_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W'(r_count) <= W'(DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_PUSH) && !full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not add an entry");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_POP) && (r_count == '0))
        |=> (o_out_valid && (o_status == ST_UNDERFLOW) && (r_count == '0)))
        else $error("pop on empty stack not reported as underflow");

    a_scan_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEEK) |-> !o_out_valid)
        else $error("result register busy during peek scan");

endmodule

[rtl/core/lifo_stack_with_peek.sv]
// lifo_stack_with_peek: top level, a chain of lsp_cell entries run by lsp_ctrl
// depends on lsp_pkg, lsp_cell, lsp_ctrl
//
// A last-in first-out store of DEPTH signed 32-bit words, built as a chain of
// cells with the top entry in cell 0; a push shifts every entry one cell down
// and a pop shifts them one cell up. Every accepted item yields exactly one
// result; a push, pop, error or unknown kind stores it on acceptance, so such
// items can be accepted back to back while results are taken. A valid peek
// at position p copies the chain into a second row of probe registers and
// shifts that row toward cell 0 one cell per cycle until entry p is in
// cell 0; no new item is taken until the peek result is stored. Capacity is
// set through i_cfg_we / i_cfg_data; the user must write it only while the
// block is idle, not enforced by the block. Zero acts as one, values above
// DEPTH act as DEPTH. Stack entries have no reset; only pushed entries are read.
module lifo_stack_with_peek #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsp_pkg::CAP_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [lsp_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [lsp_pkg::WORD_W-1:0]  i_push_value,
    input  logic [lsp_pkg::POS_W-1:0]          i_position,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [lsp_pkg::WORD_W-1:0]  o_read_value,
    output logic [lsp_pkg::STAT_W-1:0]         o_status,
    output logic                               o_is_empty,
    output logic                               o_is_full
);
    import lsp_pkg::*;

    t_cell_ctl         cell_ctl;
    logic [WORD_W-1:0] cell_data  [DEPTH];
    logic [WORD_W-1:0] cell_probe [DEPTH];
    logic [WORD_W-1:0] read_value;

    lsp_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_top_data   (cell_data[0]),
        .i_top_probe  (cell_probe[0]),
        .o_cell_ctl   (cell_ctl),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (read_value),
        .o_status     (o_status),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    assign o_read_value = $signed(read_value);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] up_data;
        logic [WORD_W-1:0] dn_data;
        logic [WORD_W-1:0] dn_probe;

        if (g == 0) begin : g_top
            assign up_data = WORD_W'(unsigned'(i_push_value));
        end else begin : g_mid
            assign up_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_bottom
            assign dn_data  = '0;
            assign dn_probe = '0;
        end else begin : g_link
            assign dn_data  = cell_data[g+1];
            assign dn_probe = cell_probe[g+1];
        end

        lsp_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_up_data  (up_data),
            .i_dn_data  (dn_data),
            .i_dn_probe (dn_probe),
            .o_data     (cell_data[g]),
            .o_probe    (cell_probe[g])
        );
    end

endmodule
